FILE: src/cffsa_pkg.sv
// ----------------------------------------------------------------------------
// cffsa_pkg
// Shared types, constants and helpers for the circular first-free slot
// allocator.
// ----------------------------------------------------------------------------
package cffsa_pkg;

  // Field widths of the transfer payloads and the count register, and its reset value
  localparam int SLOT_W    = 10;
  localparam int CNT_W     = 11;
  localparam int APB_W     = 32;
  localparam int CNT_RESET = 1024;

  // Flag memory row geometry
  localparam int ROW_W = 32;
  localparam int OFF_W = 5;

  // Request codes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_PUSH,
    ST_RFETCH,
    ST_RWR
  } state_t;

  typedef logic [ROW_W-1:0] row_t;

  // Isolate the lowest set bit of a row
  function automatic row_t lowest_onehot(input row_t v);
    lowest_onehot = v & (~v + row_t'(1));
  endfunction

  // Bit position of a one-hot row
  function automatic logic [OFF_W-1:0] onehot_index(input row_t v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (v[i]) begin
        idx = idx | OFF_W'(i);
      end
    end
    onehot_index = idx;
  endfunction

endpackage

FILE: src/circular_first_free_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// circular_first_free_slot_allocator_unit
// Keeps one occupancy flag per slot in a row-organised memory and grants the
// first free slot at or after a preferred slot, wrapping round to slot 0.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  in_       sink       in_valid / in_ready        in_func, in_slot
//  out_      source     out_valid / out_ready      out_granted_slot, out_no_free,
//                                                  out_bad_request
//  config    APB slave  psel / penable / pready    paddr, pwdata, prdata
//
//  An allocate fetches the row of the preferred slot, then searches the rows in
//  turn, wrapping round, until it finds a free slot or has come back to where
//  it began; one row of the flag memory is read and priority-encoded per cycle.
//  A release reads, modifies and writes back one row. After reset a clearing
//  pass zeroes the flag memory, with in_ready low. A result waiting on out_ready
//  holds the sequencer in its push state; in_ready is high whenever the sequencer is idle.
//
module circular_first_free_slot_allocator_unit #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [cffsa_pkg::SLOT_W-1:0]  in_slot,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cffsa_pkg::SLOT_W-1:0]  out_granted_slot,
  output logic                          out_no_free,
  output logic                          out_bad_request,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [cffsa_pkg::APB_W-1:0]   pwdata,
  output logic [cffsa_pkg::APB_W-1:0]   prdata,
  output logic                          pready
);

  import cffsa_pkg::*;

  localparam int ROWS = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Registers
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  slots_in_use_r;
  logic [RAW-1:0]    clr_r, clr_nxt;
  logic [RAW-1:0]    row_r, row_nxt;
  logic [RAW-1:0]    r0_r, r0_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              first_r, first_nxt;
  logic              final_r, final_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_nofree_r, res_nofree_nxt;
  logic              res_bad_r, res_bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_nofree_r, out_nofree_nxt;
  logic              out_bad_r, out_bad_nxt;
  row_t              rd_data_r;

  // Flag memory
  row_t              flag_mem [ROWS];
  logic              mem_we;
  logic [RAW-1:0]    mem_waddr;
  logic [RAW-1:0]    mem_raddr;
  row_t              mem_wdata;

  // Datapath signals
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_m1;
  logic [RAW-1:0]    last_row;
  logic              in_xfer;
  logic              out_free;
  logic              req_in_range;
  logic [OFF_W-1:0]  lo_off;
  logic [OFF_W:0]    hi_cnt;
  row_t              lo_mask;
  row_t              hi_mask;
  row_t              free_v;
  row_t              pick;
  logic [OFF_W-1:0]  pick_idx;
  logic              found;
  logic              at_last;
  logic [RAW-1:0]    next_row;
  logic              next_final;

  // Config register write and read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= CNT_W'(CNT_RESET);
    end else if (psel && penable && pwrite && pready) begin
      slots_in_use_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = APB_W'(slots_in_use_r) & {APB_W{paddr == 2'b00 || paddr != 2'b00}};

  // Effective count, saturated at the memory size
  assign n_eff = (APB_W'(slots_in_use_r) > APB_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                                : slots_in_use_r;
  assign n_m1     = n_eff - CNT_W'(1);
  assign last_row = RAW'(n_m1 >> OFF_W);

  assign in_ready     = (state_r == ST_IDLE);
  assign in_xfer      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign req_in_range = CNT_W'(in_slot) < n_eff;

  // Search window within the current row
  assign lo_off = first_r ? off_r : '0;
  always_comb begin
    if (final_r) begin
      hi_cnt = {1'b0, off_r};
    end else if (row_r == last_row) begin
      hi_cnt = {1'b0, n_m1[OFF_W-1:0]} + (OFF_W+1)'(1);
    end else begin
      hi_cnt = (OFF_W+1)'(ROW_W);
    end
  end
  assign lo_mask  = {ROW_W{1'b1}} << lo_off;
  assign hi_mask  = ROW_W'(({1'b0, {ROW_W{1'b0}}} | (ROW_W+1)'(1) << hi_cnt)
                           - (ROW_W+1)'(1));
  assign free_v   = ~rd_data_r & lo_mask & hi_mask;
  assign pick     = lowest_onehot(free_v);
  assign pick_idx = onehot_index(pick);
  assign found    = |free_v;

  // Next row of the circular walk
  assign at_last    = (row_r == last_row);
  assign next_row   = at_last ? '0 : row_r + RAW'(1);
  assign next_final = (next_row == r0_r) && (wrapped_r || at_last);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == RAW'(ROWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_RELEASE) begin
            state_nxt = req_in_range ? ST_RFETCH : ST_IDLE;
          end else begin
            state_nxt = req_in_range ? ST_FETCH : ST_PUSH;
          end
        end
      end
      ST_FETCH:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (found || final_r) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_RFETCH: state_nxt = ST_RWR;
      ST_RWR:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result register
  always_comb begin
    clr_nxt        = clr_r;
    row_nxt        = row_r;
    r0_nxt         = r0_r;
    off_nxt        = off_r;
    first_nxt      = first_r;
    final_nxt      = final_r;
    wrapped_nxt    = wrapped_r;
    res_slot_nxt   = res_slot_r;
    res_nofree_nxt = res_nofree_r;
    res_bad_nxt    = res_bad_r;
    out_slot_nxt   = out_slot_r;
    out_nofree_nxt = out_nofree_r;
    out_bad_nxt    = out_bad_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_waddr      = row_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = row_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + RAW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          row_nxt        = RAW'(in_slot[SLOT_W-1:OFF_W]);
          r0_nxt         = RAW'(in_slot[SLOT_W-1:OFF_W]);
          off_nxt        = in_slot[OFF_W-1:0];
          first_nxt      = 1'b1;
          final_nxt      = 1'b0;
          wrapped_nxt    = 1'b0;
          res_slot_nxt   = '0;
          res_nofree_nxt = 1'b0;
          res_bad_nxt    = !req_in_range;
        end
      end
      ST_SCAN: begin
        if (found) begin
          // Claim the slot
          mem_we       = 1'b1;
          mem_waddr    = row_r;
          mem_wdata    = rd_data_r | pick;
          res_slot_nxt = SLOT_W'({row_r, pick_idx});
        end else if (final_r) begin
          res_nofree_nxt = 1'b1;
        end else begin
          // Fetch the next row while this one is checked
          mem_raddr   = next_row;
          row_nxt     = next_row;
          first_nxt   = 1'b0;
          final_nxt   = next_final;
          wrapped_nxt = wrapped_r || at_last;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_nofree_nxt = res_nofree_r;
          out_bad_nxt    = res_bad_r;
        end
      end
      ST_RWR: begin
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = rd_data_r & ~(row_t'(1) << off_r);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    r0_r         <= r0_nxt;
    off_r        <= off_nxt;
    first_r      <= first_nxt;
    final_r      <= final_nxt;
    wrapped_r    <= wrapped_nxt;
    res_slot_r   <= res_slot_nxt;
    res_nofree_r <= res_nofree_nxt;
    res_bad_r    <= res_bad_nxt;
    out_slot_r   <= out_slot_nxt;
    out_nofree_r <= out_nofree_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  // Flag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      flag_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= flag_mem[mem_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_no_free      = out_nofree_r;
  assign out_bad_request  = out_bad_r;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the circular first-free slot allocator. A short
// directed run covers the corner cases of the slot count and of the request
// fields. Randomised allocate/release traffic then runs under several slot
// counts and handshake idling patterns. Every result is checked against a
// behavioural occupancy model kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  import cffsa_pkg::*;

  localparam int         NUM_SLOTS        = 1024;
  localparam logic [1:0] REG_SLOTS_IN_USE = 2'd0;
  localparam int         RESET_CYCLES     = 8;
  // Longer than the slowest allocate
  localparam int         SETTLE_CYCLES    = 48;
  localparam int         HOLD_CYCLES      = 400;
  localparam longint     CYCLE_LIMIT      = 1000000;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              no_free;
    logic              bad_request;
  } grant_t;

  // DUT connections, all inputs known from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              in_func   = FUNC_ALLOC;
  logic [SLOT_W-1:0] in_slot   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SLOT_W-1:0] out_granted_slot;
  logic              out_no_free;
  logic              out_bad_request;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [1:0]        paddr     = REG_SLOTS_IN_USE;
  logic [APB_W-1:0]  pwdata    = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  // Occupancy model and its slot count
  bit   [NUM_SLOTS-1:0] occupied_map;
  logic [CNT_W-1:0]     slot_count = CNT_W'(CNT_RESET);

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  request_t next_req;

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_request   = 0;
  int     hold_served    = 0;
  int     hold_left      = 0;
  longint cycle_cnt      = 0;

  int error_cnt    = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int granted_cnt  = 0;
  int full_cnt     = 0;
  int bad_cnt      = 0;
  int release_cnt  = 0;
  int write_cnt    = 0;

  circular_first_free_slot_allocator_unit #(
    .MAX_SLOTS (NUM_SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_no_free      (out_no_free),
    .out_bad_request  (out_bad_request),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  // Apply one accepted request to the occupancy model
  task automatic apply_request(input request_t req);
    int unsigned managed;
    int unsigned idx;
    grant_t      g;
    managed = (slot_count > NUM_SLOTS) ? NUM_SLOTS : slot_count;
    g = '0;
    if (req.func == FUNC_RELEASE) begin
      if (req.slot < managed) occupied_map[req.slot] = 1'b0;
      release_cnt++;
    end else begin
      if (req.slot >= managed) begin
        g.bad_request = 1'b1;
        bad_cnt++;
      end else begin
        // circular search from the preferred slot
        g.no_free = 1'b1;
        for (int i = 0; i < managed; i++) begin
          idx = req.slot + i;
          if (idx >= managed) idx -= managed;
          if (!occupied_map[idx]) begin
            occupied_map[idx] = 1'b1;
            g.granted_slot    = idx[SLOT_W-1:0];
            g.no_free         = 1'b0;
            break;
          end
        end
        if (g.no_free) full_cnt++;
        else granted_cnt++;
      end
      expected_grants.push_back(g);
    end
  endtask

  // Request driver: holds each transfer until accepted, random gaps between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request({in_func, in_slot});
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_func  <= next_req.func;
          in_slot  <= next_req.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request != hold_served) begin
        hold_served = hold_request;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result: granted_slot %0d no_free %0b bad_request %0b",
               out_granted_slot, out_no_free, out_bad_request);
        error_cnt++;
      end else begin
        want = expected_grants.pop_front();
        checked_cnt++;
        if (out_granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                 out_granted_slot);
          error_cnt++;
        end
        if (out_no_free !== want.no_free) begin
          $error("no_free: expected %0b, got %0b", want.no_free, out_no_free);
          error_cnt++;
        end
        if (out_bad_request !== want.bad_request) begin
          $error("bad_request: expected %0b, got %0b", want.bad_request,
                 out_bad_request);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_grants.size());
      $display("circular_first_free_slot_allocator_unit: mismatch");
      $finish;
    end
  end

  // APB write of the slot count: setup, access, then release the bus
  task automatic write_slot_count(input logic [CNT_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SLOTS_IN_USE;
    pwdata  <= APB_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    slot_count = value;
    write_cnt++;
    @(negedge clk);
  endtask

  // Wait for all traffic to finish, let a release complete, then for in_ready
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  task automatic push_req(input logic func, input int unsigned slot);
    request_t r;
    r.func = func;
    r.slot = slot[SLOT_W-1:0];
    pending_reqs.push_back(r);
  endtask

  // One random phase: set the count and idling pattern, queue traffic, drain
  task automatic run_random(input logic [CNT_W-1:0] count, input int send_pct,
                            input int recv_pct, input int n_reqs,
                            input int alloc_pct, input bit hold_off);
    int unsigned managed;
    request_t    r;
    write_slot_count(count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold_off) hold_request++;
    managed = (count > NUM_SLOTS) ? NUM_SLOTS : count;
    for (int k = 0; k < n_reqs; k++) begin
      r.func = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_RELEASE;
      // mostly managed slots, some anywhere in the field's range
      if (managed != 0 && $urandom_range(99) < 85) begin
        r.slot = SLOT_W'($urandom_range(managed - 1));
      end else begin
        r.slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      end
      pending_reqs.push_back(r);
    end
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Full count from reset: extremes, wrap round, release of a free slot
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_ALLOC, 1023);
    push_req(FUNC_ALLOC, 1023);
    push_req(FUNC_RELEASE, 1);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 600);
    push_req(FUNC_RELEASE, 0);
    wait_drained();

    // Shrunk count with taken slots: wrap, all full, out-of-range requests
    write_slot_count(3);
    push_req(FUNC_ALLOC, 2);
    push_req(FUNC_ALLOC, 1);
    push_req(FUNC_ALLOC, 3);
    push_req(FUNC_RELEASE, 5);
    push_req(FUNC_RELEASE, 1023);
    push_req(FUNC_ALLOC, 1023);
    wait_drained();

    // No managed slot at all
    write_slot_count(0);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 0);
    wait_drained();

    // Count above the maximum saturates; old flags count again
    write_slot_count(2047);
    push_req(FUNC_ALLOC, 1022);
    push_req(FUNC_ALLOC, 1023);
    wait_drained();

    // Single slot
    write_slot_count(1);
    push_req(FUNC_ALLOC, 0);
    push_req(FUNC_RELEASE, 0);
    push_req(FUNC_ALLOC, 0);
    wait_drained();

    // Random traffic: count, sender idle %, receiver stall %, requests,
    // allocate %, long hold-off
    run_random(1024, 0, 0, 300, 75, 1'b0);
    run_random(8, 57, 0, 200, 60, 1'b0);
    run_random(1, 0, 57, 150, 55, 1'b0);
    run_random(40, 23, 23, 250, 65, 1'b0);
    run_random(2047, 0, 0, 300, 70, 1'b1);
    run_random(33, 57, 0, 200, 60, 1'b0);
    run_random(0, 0, 57, 50, 60, 1'b0);
    run_random(1000, 23, 23, 300, 70, 1'b0);
    run_random(64, 0, 0, 250, 60, 1'b0);

    $display("%0d requests accepted: %0d grants, %0d no-free, %0d bad, %0d releases",
             accepted_cnt, granted_cnt, full_cnt, bad_cnt, release_cnt);
    $display("%0d slot-count writes, %0d results checked, %0d errors",
             write_cnt, checked_cnt, error_cnt);
    if (error_cnt == 0 && expected_grants.size() == 0) begin
      $display("circular_first_free_slot_allocator_unit: match");
    end else begin
      $display("circular_first_free_slot_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
